/* rtl/wfr_pkg.sv */
// ----------------------------------------------------------------------------
// wfr_pkg
// Shared types and constants for the weight fade ramp.
// ----------------------------------------------------------------------------
package wfr_pkg;

    localparam int WFRAC  = 16;
    localparam int WW     = WFRAC + 1;
    localparam int TICK_W = 20;
    localparam int FADE_W = 24;

    localparam logic [WW-1:0]     WONE      = WW'(1) << WFRAC;
    localparam logic [FADE_W-1:0] CFG_RESET = FADE_W'(200000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_UPD,
        ST_EMUL,
        ST_DONE
    } t_state;

endpackage

/* rtl/weight_fade_ramp_top.sv */
// ----------------------------------------------------------------------------
// weight_fade_ramp_top
// Linear crossfade gain ramp with pose weight scaling.
// ----------------------------------------------------------------------------
// A tick beat passes from accept through ADV, then MUL, DIV and SUM while a
// fade interpolates (skipped when the play timer ends at or past the fade
// end), then UPD, then EMUL when a present pose is scaled, and on to DONE; a
// tick with no pose wired goes straight to DONE. DONE waits while a previous
// result beat is still held by a stalled output. The interpolation is set by
// a restoring divider stepping one quotient bit per cycle over 17 bits; one
// multiplier is shared by the interpolation product and the pose scaling.
// Input stall is high from accept until the result is loaded into the output
// register. A tick with pose_connected low leaves the state untouched and
// returns an all-zero result.
module weight_fade_ramp_top #(
    parameter int TIME_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [wfr_pkg::FADE_W-1:0]  i_cfg_default_fade_us,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [wfr_pkg::TICK_W-1:0]  i_tick_us,
    input  logic [wfr_pkg::WW-1:0]      i_target_weight,
    input  logic                        i_fade_override_valid,
    input  logic [wfr_pkg::FADE_W-1:0]  i_fade_override_us,
    input  logic                        i_pose_connected,
    input  logic                        i_pose_present,
    input  logic                        i_pose_command_valid,
    input  logic [wfr_pkg::WW-1:0]      i_pose_weight,
    input  logic                        i_pose_root_motion,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_active,
    output logic [wfr_pkg::WW-1:0]      o_current_weight,
    output logic                        o_faded_out,
    output logic                        o_faded_in,
    output logic                        o_emit_pose,
    output logic                        o_use_rest_pose,
    output logic [wfr_pkg::WW-1:0]      o_emitted_weight,
    output logic                        o_emitted_root_motion
);

    localparam int WW    = wfr_pkg::WW;
    localparam int TB    = TIME_BITS;
    localparam int SW    = ((TB > wfr_pkg::TICK_W) ? TB : wfr_pkg::TICK_W) + 1;
    localparam int FW    = (TB > wfr_pkg::FADE_W) ? TB : wfr_pkg::FADE_W;
    localparam int MB    = (TB > WW) ? TB : WW;
    localparam int PW    = WW + MB;
    localparam int CNT_W = $clog2(WW);

    localparam logic [SW-1:0]    TMAX_S = SW'({TB{1'b1}});
    localparam logic [FW-1:0]    TMAX_F = FW'({TB{1'b1}});
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WW - 1);

    wfr_pkg::t_state r_state, n_state;

    logic [wfr_pkg::FADE_W-1:0] r_cfg_fade;

    logic [wfr_pkg::TICK_W-1:0] r_tick,    n_tick;
    logic [WW-1:0]              r_target,  n_target;
    logic [TB-1:0]              r_fade_sel, n_fade_sel;
    logic                       r_conn,    n_conn;
    logic                       r_present, n_present;
    logic                       r_cmd,     n_cmd;
    logic [WW-1:0]              r_pw,      n_pw;
    logic                       r_root,    n_root;

    logic [TB-1:0]              r_play,    n_play;
    logic [TB-1:0]              r_fade_end, n_fade_end;
    logic [WW-1:0]              r_start,   n_start;
    logic [WW-1:0]              r_end,     n_end;

    logic [PW-1:0]              r_prod,    n_prod;
    logic [TB:0]                r_rem,     n_rem;
    logic [WW-1:0]              r_dvd,     n_dvd;
    logic [WW-1:0]              r_quo,     n_quo;
    logic [CNT_W-1:0]           r_cnt,     n_cnt;

    logic [WW-1:0]              r_cur,     n_cur;
    logic                       r_fout,    n_fout;
    logic                       r_fin,     n_fin;
    logic                       r_emit,    n_emit;
    logic                       r_rest,    n_rest;
    logic                       r_scale,   n_scale;

    logic                       r_out_valid, n_out_valid;
    logic                       r_o_active,  n_o_active;
    logic [WW-1:0]              r_o_cur,     n_o_cur;
    logic                       r_o_fout,    n_o_fout;
    logic                       r_o_fin,     n_o_fin;
    logic                       r_o_emit,    n_o_emit;
    logic                       r_o_rest,    n_o_rest;
    logic [WW-1:0]              r_o_ew,      n_o_ew;
    logic                       r_o_er,      n_o_er;

    logic [WW-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic [PW-1:0] mul_p;

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != wfr_pkg::ST_IDLE);

    assign o_out_valid           = r_out_valid;
    assign o_active              = r_o_active;
    assign o_current_weight      = r_o_cur;
    assign o_faded_out           = r_o_fout;
    assign o_faded_in            = r_o_fin;
    assign o_emit_pose           = r_o_emit;
    assign o_use_rest_pose       = r_o_rest;
    assign o_emitted_weight      = r_o_ew;
    assign o_emitted_root_motion = r_o_er;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wfr_pkg::ST_IDLE;
            r_cfg_fade  <= wfr_pkg::CFG_RESET;
            r_play      <= '0;
            r_fade_end  <= '0;
            r_start     <= '0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_play      <= n_play;
            r_fade_end  <= n_fade_end;
            r_start     <= n_start;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_fade <= i_cfg_default_fade_us;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tick     <= n_tick;
        r_target   <= n_target;
        r_fade_sel <= n_fade_sel;
        r_conn     <= n_conn;
        r_present  <= n_present;
        r_cmd      <= n_cmd;
        r_pw       <= n_pw;
        r_root     <= n_root;
        r_prod     <= n_prod;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_cur      <= n_cur;
        r_fout     <= n_fout;
        r_fin      <= n_fin;
        r_emit     <= n_emit;
        r_rest     <= n_rest;
        r_scale    <= n_scale;
        r_o_active <= n_o_active;
        r_o_cur    <= n_o_cur;
        r_o_fout   <= n_o_fout;
        r_o_fin    <= n_o_fin;
        r_o_emit   <= n_o_emit;
        r_o_rest   <= n_o_rest;
        r_o_ew     <= n_o_ew;
        r_o_er     <= n_o_er;
    end

    always_comb begin
        logic [FW-1:0] fade_raw;
        logic [SW-1:0] play_sum;
        logic [TB-1:0] play_sat;
        logic [WW-1:0] diff;
        logic [TB:0]   trial;
        logic          qbit;

        n_state     = r_state;
        n_tick      = r_tick;
        n_target    = r_target;
        n_fade_sel  = r_fade_sel;
        n_conn      = r_conn;
        n_present   = r_present;
        n_cmd       = r_cmd;
        n_pw        = r_pw;
        n_root      = r_root;
        n_play      = r_play;
        n_fade_end  = r_fade_end;
        n_start     = r_start;
        n_end       = r_end;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_fout      = r_fout;
        n_fin       = r_fin;
        n_emit      = r_emit;
        n_rest      = r_rest;
        n_scale     = r_scale;
        n_out_valid = r_out_valid;
        n_o_active  = r_o_active;
        n_o_cur     = r_o_cur;
        n_o_fout    = r_o_fout;
        n_o_fin     = r_o_fin;
        n_o_emit    = r_o_emit;
        n_o_rest    = r_o_rest;
        n_o_ew      = r_o_ew;
        n_o_er      = r_o_er;

        fade_raw = i_fade_override_valid ? FW'(i_fade_override_us) : FW'(r_cfg_fade);
        play_sum = SW'(r_play) + SW'(r_tick);
        play_sat = (play_sum > TMAX_S) ? {TB{1'b1}} : play_sum[TB-1:0];
        diff     = (r_end >= r_start) ? (r_end - r_start) : (r_start - r_end);
        trial    = {r_rem[TB-1:0], r_dvd[WW-1]};
        qbit     = (trial >= {1'b0, r_fade_end});

        mul_a = diff;
        mul_b = MB'(r_play);
        if (r_state == wfr_pkg::ST_EMUL) begin
            mul_a = r_pw;
            mul_b = MB'(r_cur);
        end

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            wfr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_tick     = i_tick_us;
                    n_target   = (i_target_weight > wfr_pkg::WONE) ?
                                 wfr_pkg::WONE : i_target_weight;
                    n_fade_sel = (fade_raw > TMAX_F) ? {TB{1'b1}} : fade_raw[TB-1:0];
                    n_conn     = i_pose_connected;
                    n_present  = i_pose_present;
                    n_cmd      = i_pose_command_valid;
                    n_pw       = (i_pose_weight > wfr_pkg::WONE) ?
                                 wfr_pkg::WONE : i_pose_weight;
                    n_root     = i_pose_root_motion;
                    n_cur      = '0;
                    n_fout     = 1'b0;
                    n_fin      = 1'b0;
                    n_emit     = 1'b0;
                    n_rest     = 1'b0;
                    n_scale    = 1'b0;
                    n_state    = i_pose_connected ? wfr_pkg::ST_ADV : wfr_pkg::ST_DONE;
                end
            end
            wfr_pkg::ST_ADV: begin
                n_play = play_sat;
                if (play_sat >= r_fade_end) begin
                    n_cur   = r_end;
                    n_fout  = (r_play < r_fade_end) && (r_end == '0);
                    n_fin   = (r_play < r_fade_end) && (r_end >= wfr_pkg::WONE);
                    n_state = wfr_pkg::ST_UPD;
                end else begin
                    n_state = wfr_pkg::ST_MUL;
                end
            end
            wfr_pkg::ST_MUL: begin
                // product < diff * fade_end, so the upper part starts below the divisor
                n_rem   = {1'b0, mul_p[WW+TB-1:WW]};
                n_dvd   = mul_p[WW-1:0];
                n_quo   = '0;
                n_cnt   = '0;
                n_state = wfr_pkg::ST_DIV;
            end
            wfr_pkg::ST_DIV: begin
                n_rem = qbit ? (trial - {1'b0, r_fade_end}) : trial;
                n_dvd = {r_dvd[WW-2:0], 1'b0};
                n_quo = {r_quo[WW-2:0], qbit};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = wfr_pkg::ST_SUM;
                end
            end
            wfr_pkg::ST_SUM: begin
                n_cur   = (r_end >= r_start) ? (r_start + r_quo) : (r_start - r_quo);
                n_state = wfr_pkg::ST_UPD;
            end
            wfr_pkg::ST_UPD: begin
                if (r_end != r_target) begin
                    n_start    = r_cur;
                    n_end      = r_target;
                    n_play     = '0;
                    n_fade_end = r_fade_sel;
                end
                n_emit  = (r_cur != '0) && (!r_present || r_cmd);
                n_rest  = (r_cur != '0) && !r_present;
                n_scale = (r_cur != '0) && r_present && r_cmd;
                n_state = ((r_cur != '0) && r_present && r_cmd) ?
                          wfr_pkg::ST_EMUL : wfr_pkg::ST_DONE;
            end
            wfr_pkg::ST_EMUL: begin
                n_prod  = mul_p;
                n_state = wfr_pkg::ST_DONE;
            end
            wfr_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_active  = r_conn;
                    n_o_cur     = r_cur;
                    n_o_fout    = r_fout;
                    n_o_fin     = r_fin;
                    n_o_emit    = r_emit;
                    n_o_rest    = r_rest;
                    n_o_ew      = r_rest ? r_cur :
                                  (r_scale ? r_prod[wfr_pkg::WFRAC +: WW] : '0);
                    n_o_er      = r_scale ? r_root : 1'b0;
                    n_state     = wfr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wfr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* bench/fade_ramp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fade_ramp_checker
// Watches the tick, result and default-fade channels of the weight fade ramp.
// It keeps its own copy of the fade state and works out the result of every
// accepted tick. It then compares each returned result, field by field, with
// the oldest result still owed.
// ----------------------------------------------------------------------------
module fade_ramp_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        o_cfg_ready,
    input  logic [wfr_pkg::FADE_W-1:0]  i_cfg_default_fade_us,
    input  logic                        i_in_valid,
    input  logic                        o_in_stall,
    input  logic [wfr_pkg::TICK_W-1:0]  i_tick_us,
    input  logic [wfr_pkg::WW-1:0]      i_target_weight,
    input  logic                        i_fade_override_valid,
    input  logic [wfr_pkg::FADE_W-1:0]  i_fade_override_us,
    input  logic                        i_pose_connected,
    input  logic                        i_pose_present,
    input  logic                        i_pose_command_valid,
    input  logic [wfr_pkg::WW-1:0]      i_pose_weight,
    input  logic                        i_pose_root_motion,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic                        o_active,
    input  logic [wfr_pkg::WW-1:0]      o_current_weight,
    input  logic                        o_faded_out,
    input  logic                        o_faded_in,
    input  logic                        o_emit_pose,
    input  logic                        o_use_rest_pose,
    input  logic [wfr_pkg::WW-1:0]      o_emitted_weight,
    input  logic                        o_emitted_root_motion,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_results,
    output int                          o_pulses
);

    localparam int                TICK_W    = wfr_pkg::TICK_W;
    localparam int                FADE_W    = wfr_pkg::FADE_W;
    localparam int                WW        = wfr_pkg::WW;
    localparam int                WFRAC     = wfr_pkg::WFRAC;
    localparam logic [WW-1:0]     WONE      = wfr_pkg::WONE;
    localparam logic [FADE_W-1:0] CFG_RESET = wfr_pkg::CFG_RESET;

    localparam int TIME_BITS = 24;
    localparam longint unsigned TIME_MAX = (64'd1 << TIME_BITS) - 1;

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [WW-1:0]     target;
        logic              ovr_valid;
        logic [FADE_W-1:0] ovr;
        logic              connected;
        logic              present;
        logic              cmd_valid;
        logic [WW-1:0]     pose_weight;
        logic              root_motion;
    } t_tick_beat;

    typedef struct packed {
        logic          active;
        logic [WW-1:0] current_weight;
        logic          faded_out;
        logic          faded_in;
        logic          emit_pose;
        logic          use_rest_pose;
        logic [WW-1:0] emitted_weight;
        logic          emitted_root_motion;
    } t_fade_result;

    logic [FADE_W-1:0]    default_fade;
    logic [TIME_BITS-1:0] play_time;
    logic [TIME_BITS-1:0] fade_end;
    logic [WW-1:0]        start_w;
    logic [WW-1:0]        end_w;
    t_fade_result         owed_q[$];

    function automatic t_fade_result advance_fade(input t_tick_beat b);
        t_fade_result r;
        longint unsigned tgt, pw, cur, sum, ew;
        logic was_running;
        r = '0;
        if (!b.connected) begin
            return r;
        end
        tgt = (b.target > WONE) ? WONE : b.target;
        pw  = (b.pose_weight > WONE) ? WONE : b.pose_weight;
        was_running = play_time < fade_end;
        sum = longint'(play_time) + b.tick;
        play_time = (sum > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : sum[TIME_BITS-1:0];

        if (play_time >= fade_end) begin
            cur = end_w;
            r.faded_out = was_running && (cur == 0);
            r.faded_in  = was_running && (cur >= WONE);
        end else if (end_w >= start_w) begin
            cur = start_w + ((longint'(end_w - start_w) * play_time) / fade_end);
        end else begin
            cur = start_w - ((longint'(start_w - end_w) * play_time) / fade_end);
        end

        if (end_w != tgt[WW-1:0]) begin
            start_w   = cur[WW-1:0];
            end_w     = tgt[WW-1:0];
            play_time = '0;
            fade_end  = b.ovr_valid ? b.ovr : default_fade;
        end

        if (cur != 0) begin
            if (!b.present) begin
                r.emit_pose      = 1'b1;
                r.use_rest_pose  = 1'b1;
                r.emitted_weight = cur[WW-1:0];
            end else if (b.cmd_valid) begin
                ew                    = (pw * cur) >> WFRAC;
                r.emit_pose           = 1'b1;
                r.emitted_weight      = ew[WW-1:0];
                r.emitted_root_motion = b.root_motion;
            end
        end
        r.active         = 1'b1;
        r.current_weight = cur[WW-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_fade_result want;
        t_tick_beat   beat;
        if (!i_rst_n) begin
            default_fade = CFG_RESET;
            play_time    = '0;
            fade_end     = '0;
            start_w      = '0;
            end_w        = '0;
            owed_q.delete();
            o_fail_count = 0;
            o_results    = 0;
            o_pulses     = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_results++;
                if (owed_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result beat with nothing owed, weight %0h", $time,
                             o_current_weight);
                end else begin
                    want = owed_q.pop_front();
                    if (want.faded_in || want.faded_out) begin
                        o_pulses++;
                    end
                    check_field("active", want.active, o_active);
                    check_field("current_weight", want.current_weight, o_current_weight);
                    check_field("faded_out", want.faded_out, o_faded_out);
                    check_field("faded_in", want.faded_in, o_faded_in);
                    check_field("emit_pose", want.emit_pose, o_emit_pose);
                    check_field("use_rest_pose", want.use_rest_pose, o_use_rest_pose);
                    check_field("emitted_weight", want.emitted_weight, o_emitted_weight);
                    check_field("emitted_root_motion", want.emitted_root_motion,
                                o_emitted_root_motion);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                default_fade = i_cfg_default_fade_us;
            end
            if (i_in_valid && !o_in_stall) begin
                beat = {i_tick_us, i_target_weight, i_fade_override_valid, i_fade_override_us,
                        i_pose_connected, i_pose_present, i_pose_command_valid,
                        i_pose_weight, i_pose_root_motion};
                owed_q.push_back(advance_fade(beat));
            end
        end
        o_pending = owed_q.size();
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the weight fade ramp with directed ticks, then with random fades,
// long timer runs and noise under several default fade durations. Both sides
// pace their beats at random. The checker beside the block predicts and
// compares every result; this module only drives the block and reports.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int                TICK_W = wfr_pkg::TICK_W;
    localparam int                FADE_W = wfr_pkg::FADE_W;
    localparam int                WW     = wfr_pkg::WW;
    localparam logic [WW-1:0]     WONE   = wfr_pkg::WONE;

    localparam int          IDLE_LIMIT  = 4000;
    localparam int          PHASE_ITEMS = 290;
    localparam int unsigned TICK_MAX    = (1 << TICK_W) - 1;
    localparam int unsigned FADE_MAX    = 10000000;

    logic              i_clk                 = 1'b0;
    logic              i_rst_n               = 1'b0;
    logic              i_cfg_valid           = 1'b0;
    logic [FADE_W-1:0] i_cfg_default_fade_us = '0;
    logic              i_in_valid            = 1'b0;
    logic [TICK_W-1:0] i_tick_us             = '0;
    logic [WW-1:0]     i_target_weight       = '0;
    logic              i_fade_override_valid = 1'b0;
    logic [FADE_W-1:0] i_fade_override_us    = '0;
    logic              i_pose_connected      = 1'b0;
    logic              i_pose_present        = 1'b0;
    logic              i_pose_command_valid  = 1'b0;
    logic [WW-1:0]     i_pose_weight         = '0;
    logic              i_pose_root_motion    = 1'b0;
    logic              i_out_stall           = 1'b0;

    logic              o_cfg_ready;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_active;
    logic [WW-1:0]     o_current_weight;
    logic              o_faded_out;
    logic              o_faded_in;
    logic              o_emit_pose;
    logic              o_use_rest_pose;
    logic [WW-1:0]     o_emitted_weight;
    logic              o_emitted_root_motion;

    int o_fail_count;
    int o_pending;
    int o_results;
    int o_pulses;

    int          beats_sent     = 0;
    int          connected_sent = 0;
    int          cfg_writes     = 0;
    int          idle_cycles    = 0;
    int unsigned fade_now       = 200000;
    int unsigned stall_left     = 0;
    logic        in_quiet       = 1'b0;
    logic        out_quiet      = 1'b0;

    weight_fade_ramp_top dut (.*);

    fade_ramp_checker checker_i (.*);

    always #4 i_clk = ~i_clk;

    // result side: a random wait is drawn for the next result beat
    always @(posedge i_clk) begin : out_pace
        int unsigned n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            n = out_quiet ? 0 : $urandom_range(0, 7);
            i_out_stall <= (n != 0);
            stall_left  <= n;
            if ($urandom_range(0, 31) == 0) begin
                out_quiet <= ~out_quiet;
            end
        end else if (o_out_valid && i_out_stall) begin
            stall_left <= stall_left - 1;
            if (stall_left <= 1) begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles, %0d results owed", $time, IDLE_LIMIT,
                     o_pending);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [WW-1:0] pick_weight();
        case ($urandom_range(0, 7))
            0, 1:    return '0;
            2, 3:    return WONE;
            default: return WW'($urandom_range(0, WONE));
        endcase
    endfunction

    function automatic logic [FADE_W-1:0] pick_fade();
        case ($urandom_range(0, 7))
            0:          return '0;
            1:          return FADE_W'(FADE_MAX);
            2, 3, 4, 5: return FADE_W'($urandom_range(1, 5000));
            default:    return FADE_W'($urandom_range(0, FADE_MAX));
        endcase
    endfunction

    task automatic send_tick(input logic [TICK_W-1:0] tick, input logic [WW-1:0] tgt,
                             input logic ov, input logic [FADE_W-1:0] ovr,
                             input logic conn, input logic pres, input logic cmd,
                             input logic [WW-1:0] pw, input logic root);
        int unsigned gap;
        gap = in_quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid            <= 1'b1;
        i_tick_us             <= tick;
        i_target_weight       <= tgt;
        i_fade_override_valid <= ov;
        i_fade_override_us    <= ovr;
        i_pose_connected      <= conn;
        i_pose_present        <= pres;
        i_pose_command_valid  <= cmd;
        i_pose_weight         <= pw;
        i_pose_root_motion    <= root;
        do @(posedge i_clk); while (o_in_stall);
        beats_sent++;
        if (conn) begin
            connected_sent++;
        end
    endtask

    task automatic send_random_pose(input logic [TICK_W-1:0] tick, input logic [WW-1:0] tgt,
                                    input logic ov, input logic [FADE_W-1:0] ovr);
        send_tick(tick, tgt, ov, ovr, $urandom_range(0, 11) != 0, $urandom_range(0, 3) != 0,
                  $urandom_range(0, 3) != 0, pick_weight(), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        wait (o_results == beats_sent);
    endtask

    task automatic write_default(input logic [FADE_W-1:0] val);
        i_cfg_valid           <= 1'b1;
        i_cfg_default_fade_us <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        fade_now = val;
        cfg_writes++;
    endtask

    task automatic random_sequence();
        int unsigned kind, n, span, dur;
        logic [WW-1:0]     tgt;
        logic              ov;
        logic [FADE_W-1:0] ovr;
        kind     = $urandom_range(0, 9);
        in_quiet = ($urandom_range(0, 4) == 0);
        tgt      = pick_weight();
        ov       = 1'($urandom_range(0, 1));
        ovr      = pick_fade();
        if (kind < 7) begin
            // a fade toward one target, ticks sized so that it often completes
            dur  = ov ? ovr : fade_now;
            n    = $urandom_range(2, 12);
            span = dur / n * 2 + 1;
            if (span > TICK_MAX) begin
                span = TICK_MAX;
            end
            repeat (n) send_random_pose(TICK_W'($urandom_range(0, span)), tgt, ov, ovr);
        end else if (kind < 8) begin
            // long hold with large ticks drives the play timer into saturation
            repeat (18) begin
                send_random_pose(TICK_W'($urandom_range(TICK_MAX - 4096, TICK_MAX)),
                                 tgt, ov, ovr);
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                send_random_pose(TICK_W'($urandom_range(0, TICK_MAX)), pick_weight(),
                                 1'($urandom_range(0, 1)), pick_fade());
            end
        end
    endtask

    initial begin
        logic [FADE_W-1:0] phase_fade[5];
        int                phase_goal;
        phase_fade = '{FADE_W'(FADE_MAX), '0, FADE_W'(2500),
                       FADE_W'($urandom_range(1, FADE_MAX)), FADE_W'(40000)};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_tick(TICK_W'(TICK_MAX), WONE, 1'b1, FADE_W'(FADE_MAX),
                  1'b0, 1'b1, 1'b1, WONE, 1'b1);
        send_tick(TICK_W'(0), WONE, 1'b1, FADE_W'(100), 1'b1, 1'b0, 1'b0, WW'(0), 1'b0);
        send_tick(TICK_W'(50), WONE, 1'b0, FADE_W'(0), 1'b1, 1'b0, 1'b1, WONE, 1'b1);
        send_tick(TICK_W'(TICK_MAX), WONE, 1'b0, FADE_W'(0), 1'b1, 1'b1, 1'b1, WONE, 1'b1);
        send_tick(TICK_W'(0), WW'(0), 1'b0, FADE_W'(0), 1'b1, 1'b1, 1'b0, WONE, 1'b1);
        send_tick(TICK_W'(100000), WW'(0), 1'b0, FADE_W'(0), 1'b1, 1'b1, 1'b1, WW'(1), 1'b0);
        send_tick(TICK_W'(TICK_MAX), WW'(0), 1'b0, FADE_W'(0), 1'b1, 1'b1, 1'b1, WONE, 1'b1);
        send_tick(TICK_W'(5), WW'(0), 1'b0, FADE_W'(0), 1'b1, 1'b0, 1'b0, WW'(0), 1'b0);
        send_tick(TICK_W'(0), WW'(21845), 1'b1, FADE_W'(0), 1'b1, 1'b1, 1'b1,
                  WW'(43690), 1'b1);
        send_tick(TICK_W'(0), WW'(21845), 1'b0, FADE_W'(0), 1'b1, 1'b1, 1'b1,
                  WW'(43690), 1'b1);
        send_tick(TICK_W'(7), WONE, 1'b1, FADE_W'(FADE_MAX), 1'b1, 1'b1, 1'b1,
                  WW'(65535), 1'b0);
        send_tick(TICK_W'(12345), WONE, 1'b0, FADE_W'(0), 1'b1, 1'b0, 1'b0, WW'(0), 1'b1);
        send_tick(TICK_W'(999999), WW'(100), 1'b1, FADE_W'(3), 1'b1, 1'b1, 1'b1,
                  WW'(32768), 1'b1);
        send_tick(TICK_W'(1), WW'(100), 1'b0, FADE_W'(0), 1'b1, 1'b1, 1'b1,
                  WW'(32768), 1'b0);
        send_tick(TICK_W'(1), WW'(100), 1'b0, FADE_W'(0), 1'b1, 1'b0, 1'b1, WW'(0), 1'b1);
        send_tick(TICK_W'(1), WW'(100), 1'b0, FADE_W'(0), 1'b1, 1'b1, 1'b1, WONE, 1'b1);
        send_tick(TICK_W'(3), WW'(0), 1'b1, FADE_W'(5), 1'b0, 1'b1, 1'b1, WONE, 1'b1);
        send_tick(TICK_W'(0), WW'(65535), 1'b1, FADE_W'(2), 1'b1, 1'b1, 1'b1,
                  WW'(65535), 1'b1);
        send_tick(TICK_W'(1), WONE, 1'b1, FADE_W'(2), 1'b1, 1'b1, 1'b1, WONE, 1'b0);
        send_tick(TICK_W'(2), WONE, 1'b0, FADE_W'(0), 1'b1, 1'b1, 1'b1, WW'(12345), 1'b1);

        foreach (phase_fade[p]) begin
            drain();
            write_default(phase_fade[p]);
            phase_goal = connected_sent + PHASE_ITEMS;
            while (connected_sent < phase_goal) begin
                random_sequence();
            end
        end
        drain();
        repeat (30) @(posedge i_clk);

        $display("%0d tick beats sent (%0d with no pose wired), %0d results compared",
                 beats_sent, beats_sent - connected_sent, o_results);
        $display("%0d fade-end pulses over %0d default fade settings", o_pulses, cfg_writes);
        if (o_pending != 0) begin
            $display("%0d results never returned", o_pending);
        end
        if (o_fail_count == 0 && o_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/wfr_pkg.sv
rtl/weight_fade_ramp_top.sv
bench/fade_ramp_checker.sv
bench/tb_top.sv
